FILE: hdl/ret_pkg.sv
// Shared constants, types and arithmetic helpers for the row edge tracker.
package ret_pkg;

   // Image geometry
   localparam int ImageWidth  = 188;
   localparam int ImageHeight = 120;

   localparam int RowW   = 7;
   localparam int ColW   = 8;
   localparam int PixW   = 8;
   localparam int ThrW   = 9;
   localparam int CountW = 7;
   localparam int AddrW  = $clog2(ImageHeight);

   localparam logic [ColW-1:0] LastCol     = ColW'(ImageWidth - 1);
   localparam logic [ColW-1:0] HalfWidth   = ColW'(ImageWidth / 2);
   localparam logic [RowW-1:0] FirstRow    = RowW'(ImageHeight - 1);
   localparam logic [RowW-1:0] RowLimit    = RowW'(ImageHeight);
   localparam logic [ThrW-1:0] ThrReset    = ThrW'(50);

   // Reciprocal of ten in 16 fractional bits, exact for values below 16384
   localparam logic [12:0] Recip10 = 13'd6554;

   typedef logic [RowW-1:0]   row_type;
   typedef logic [ColW-1:0]   col_type;
   typedef logic [PixW-1:0]   pix_type;
   typedef logic [ThrW-1:0]   thr_type;
   typedef logic [CountW-1:0] count_type;

   // Row-start request toward the start column tracker
   typedef struct packed {
      logic    start;   // column zero of a valid row
      logic    frame;   // that row is the first row of a frame
      col_type center;  // stored center line for that row
   } begin_type;

   // Search windows handed back to the edge scan
   typedef struct packed {
      col_type left_start;
      col_type right_start;
   } start_type;

   // floor(x / 10) for an 11-bit value
   function automatic col_type div10(input logic [10:0] x);
      logic [23:0] prod;
      prod = 24'(x) * 24'(Recip10);
      return prod[23:16];
   endfunction

   // 256*|a-b| > thr*(a+b)
   function automatic logic is_edge(input pix_type a, input pix_type b, input thr_type thr);
      pix_type     d;
      logic [8:0]  sum;
      logic [17:0] lhs;
      logic [17:0] rhs;
      d   = (a > b) ? (a - b) : (b - a);
      sum = {1'b0, a} + {1'b0, b};
      lhs = {2'b00, d, 8'h00};
      rhs = 18'(thr) * 18'(sum);
      return lhs > rhs;
   endfunction

endpackage

FILE: hdl/row_edge_tracker_diff_sum_ratio.sv
// Top level: input register, edge scan, per-row result register.
// A row's result is registered after its last pixel has passed the input register.
// Throughput: one pixel per cycle; the scan stage is a single registered pass per pixel,
// stalling only while a finished row result waits to be taken.
// Reset: synchronous, active high; threshold returns to 50, all edge state to its start
// values, and the center store's per-row valid bits are cleared at once (no clearing pass).
module row_edge_tracker_diff_sum_ratio
   import ret_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   // pixel input
   input  logic      req_valid,
   output logic      req_ready,
   input  row_type   req_row_index,
   input  col_type   req_col_index,
   input  pix_type   req_pixel,
   // row result
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output row_type   rsp_row_out,
   output col_type   rsp_left_edge,
   output col_type   rsp_right_edge,
   output col_type   rsp_center_col,
   output logic      rsp_left_found,
   output logic      rsp_right_found,
   output count_type rsp_left_total,
   output count_type rsp_right_total,
   // threshold register
   input  logic      csr_wr_en,
   input  thr_type   csr_wr_data
);

   // threshold register
   thr_type thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ThrReset;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // input stage
   logic    s1_valid_ff, s1_valid_in;
   row_type s1_row_ff;
   col_type s1_col_ff;
   pix_type s1_pix_ff;

   logic rsp_valid_ff, rsp_valid_in;

   logic accept;
   logic s1_live;
   logic s1_emit;
   logic s1_go;
   logic out_free;

   assign s1_live  = s1_valid_ff && (s1_row_ff != '0) && (s1_row_ff < RowLimit)
                   && (s1_col_ff < LastCol + 8'd1);
   assign s1_emit  = s1_live && (s1_col_ff == LastCol);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_go    = s1_valid_ff && (!s1_emit || out_free);
   assign req_ready = !s1_valid_ff || s1_go;
   assign accept   = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff <= req_row_index;
         s1_col_ff <= req_col_index;
         s1_pix_ff <= req_pixel;
      end
   end

   // center line store, read at the beat and used in the scan stage
   col_type center_rd;
   col_type center_wr;
   logic    mem_rd_en;
   logic    mem_wr_en;

   assign mem_rd_en = accept && (req_row_index < RowLimit);
   assign mem_wr_en = s1_go && s1_emit;

   ret_center_mem u_center_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (req_row_index[AddrW-1:0]),
      .wr_en   (mem_wr_en),
      .wr_addr (s1_row_ff[AddrW-1:0]),
      .wr_data (center_wr),
      .rd_data (center_rd)
   );

   // start columns
   begin_type row_begin;
   start_type window;

   assign row_begin.start  = s1_go && s1_live && (s1_col_ff == '0);
   assign row_begin.frame  = (s1_row_ff == FirstRow);
   assign row_begin.center = center_rd;

   ret_start_track u_start_track (
      .clock     (clock),
      .reset     (reset),
      .row_begin (row_begin),
      .window    (window)
   );

   // pixel delay line, three deep
   pix_type dly0_ff, dly1_ff, dly2_ff;
   always_ff @(posedge clock) begin
      if (s1_go) begin
         dly0_ff <= s1_pix_ff;
         dly1_ff <= dly0_ff;
         dly2_ff <= dly1_ff;
      end
   end

   // edge scan state
   col_type   left_edge_ff,  left_edge_in;
   col_type   right_edge_ff, right_edge_in;
   logic      left_hit_ff,   left_hit_in;
   logic      right_hit_ff,  right_hit_in;
   count_type left_cnt_ff,   left_cnt_in;
   count_type right_cnt_ff,  right_cnt_in;

   logic       hit;
   col_type    lc;
   logic [8:0] edge_sum;

   always_comb begin
      hit = is_edge(dly2_ff, s1_pix_ff, thr_ff);
      lc  = s1_col_ff - 8'd3;

      left_edge_in  = left_edge_ff;
      right_edge_in = right_edge_ff;
      left_hit_in   = left_hit_ff;
      right_hit_in  = right_hit_ff;
      left_cnt_in   = left_cnt_ff;
      right_cnt_in  = right_cnt_ff;

      if (s1_go && s1_live) begin
         // row start
         if (s1_col_ff == '0) begin
            left_edge_in  = '0;
            right_edge_in = LastCol;
            left_hit_in   = 1'b0;
            right_hit_in  = 1'b0;
            if (row_begin.frame) begin
               left_cnt_in  = '0;
               right_cnt_in = '0;
            end
         end
         // pair test, on the even grid from each start column
         if (s1_col_ff >= 8'd3 && hit) begin
            if (!left_hit_ff && (lc >= window.left_start)
                && (lc[0] == window.left_start[0])) begin
               left_hit_in  = 1'b1;
               left_edge_in = s1_col_ff - 8'd1;
            end
            if ((s1_col_ff <= window.right_start)
                && (s1_col_ff[0] == window.right_start[0])) begin
               right_hit_in  = 1'b1;
               right_edge_in = s1_col_ff - 8'd2;
            end
         end
         // row end
         if (s1_emit) begin
            if (left_hit_in) begin
               left_cnt_in = left_cnt_ff + 7'd1;
            end
            if (right_hit_in) begin
               right_cnt_in = right_cnt_ff + 7'd1;
            end
         end
      end

      edge_sum  = {1'b0, left_edge_in} + {1'b0, right_edge_in};
      center_wr = edge_sum[8:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_edge_ff  <= '0;
         right_edge_ff <= LastCol;
         left_hit_ff   <= 1'b0;
         right_hit_ff  <= 1'b0;
         left_cnt_ff   <= '0;
         right_cnt_ff  <= '0;
      end else begin
         left_edge_ff  <= left_edge_in;
         right_edge_ff <= right_edge_in;
         left_hit_ff   <= left_hit_in;
         right_hit_ff  <= right_hit_in;
         left_cnt_ff   <= left_cnt_in;
         right_cnt_ff  <= right_cnt_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (mem_wr_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   row_type   rsp_row_ff;
   col_type   rsp_left_ff, rsp_right_ff, rsp_center_ff;
   logic      rsp_lfound_ff, rsp_rfound_ff;
   count_type rsp_ltotal_ff, rsp_rtotal_ff;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         rsp_row_ff    <= s1_row_ff;
         rsp_left_ff   <= left_edge_in;
         rsp_right_ff  <= right_edge_in;
         rsp_center_ff <= center_wr;
         rsp_lfound_ff <= left_hit_in;
         rsp_rfound_ff <= right_hit_in;
         rsp_ltotal_ff <= left_cnt_in;
         rsp_rtotal_ff <= right_cnt_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_out     = rsp_row_ff;
   assign rsp_left_edge   = rsp_left_ff;
   assign rsp_right_edge  = rsp_right_ff;
   assign rsp_center_col  = rsp_center_ff;
   assign rsp_left_found  = rsp_lfound_ff;
   assign rsp_right_found = rsp_rfound_ff;
   assign rsp_left_total  = rsp_ltotal_ff;
   assign rsp_right_total = rsp_rtotal_ff;

   // a found left edge is always at least two columns in
   a_left_edge_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_left_found |-> rsp_left_edge >= 8'd2)
      else $error("left edge found below column two");

   // a row with no right edge reports the last column
   a_right_default: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_right_found |-> rsp_right_edge == LastCol)
      else $error("missing right edge not reported as last column");

   // the scan stage only holds while a row result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |-> rsp_valid_ff && !rsp_ready)
      else $error("scan stage stalled without a waiting result");

endmodule

FILE: hdl/ret_center_mem.sv
// Center line store: one entry per row, cleared by reset through per-entry valid bits.
module ret_center_mem
   import ret_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  col_type          wr_data,
   output col_type          rd_data
);

   col_type                mem [ImageHeight];
   logic [ImageHeight-1:0] valid_ff;
   col_type                rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read, with bypass of a write to the same row on the same edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else if (valid_ff[rd_addr]) begin
            rd_data_ff <= mem[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/ret_start_track.sv
// Start column tracker: low-pass filters the search start columns from the stored center line.
module ret_start_track
   import ret_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  begin_type row_begin,
   output start_type window
);

   col_type start_col_ff,   start_col_in;
   col_type left_start_ff,  left_start_in;
   col_type right_start_ff, right_start_in;

   logic [10:0] mix;
   logic [10:0] six_c;
   col_type     new_start;
   col_type     offset;
   logic [8:0]  right_sum;

   // new start = floor((4c + 3s + W) / 10), right start = min(start + floor(6c/10), W-1)
   always_comb begin
      mix       = {1'b0, row_begin.center, 2'b00}
                + 11'(start_col_ff) + 11'({start_col_ff, 1'b0})
                + 11'(ImageWidth);
      six_c     = 11'({row_begin.center, 2'b00}) + 11'({row_begin.center, 1'b0});
      new_start = div10(mix);
      offset    = div10(six_c);
      right_sum = {1'b0, new_start} + {1'b0, offset};

      start_col_in   = start_col_ff;
      left_start_in  = left_start_ff;
      right_start_in = right_start_ff;
      if (row_begin.start) begin
         if (row_begin.frame) begin
            start_col_in   = HalfWidth;
            left_start_in  = '0;
            right_start_in = LastCol;
         end else begin
            start_col_in   = new_start;
            left_start_in  = new_start;
            right_start_in = (right_sum > 9'(LastCol)) ? LastCol : right_sum[ColW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_col_ff   <= HalfWidth;
         left_start_ff  <= '0;
         right_start_ff <= LastCol;
      end else begin
         start_col_ff   <= start_col_in;
         left_start_ff  <= left_start_in;
         right_start_ff <= right_start_in;
      end
   end

   assign window.left_start  = left_start_ff;
   assign window.right_start = right_start_ff;

endmodule

FILE: dv/tb_top.sv
// Testbench for the row edge tracker: pixel rows in, per-row edge reports checked.
`timescale 1ns / 1ps

module tb_top;
   import ret_pkg::*;

   localparam int StallLimit = 5000;   // cycles with no beat on either side
   localparam int LongHold   = 1000;   // receiver hold-off, long enough to back up the input
   localparam int PrintLimit = 200;
   localparam int RowMax     = 2**RowW - 1;
   localparam int ColMax     = 2**ColW - 1;
   localparam int ThrMax     = 256;

   typedef enum {ROW_LANE, ROW_SOFT, ROW_EXTREME, ROW_FLAT, ROW_RANDOM} row_style_type;
   typedef enum {NOISE_NONE, NOISE_JUNK, NOISE_SKIP, NOISE_REPEAT, NOISE_NO_COL0,
                 NOISE_SHORT} row_noise_type;
   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_type;

   typedef struct {
      row_type row;
      col_type col;
      pix_type pix;
   } pix_beat_type;

   typedef struct {
      row_type   row;
      col_type   left_col;
      col_type   right_col;
      col_type   center;
      logic      left_hit;
      logic      right_hit;
      count_type left_cnt;
      count_type right_cnt;
   } edge_report_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   row_type   req_row_index = '0;
   col_type   req_col_index = '0;
   pix_type   req_pixel = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   row_type   rsp_row_out;
   col_type   rsp_left_edge;
   col_type   rsp_right_edge;
   col_type   rsp_center_col;
   logic      rsp_left_found;
   logic      rsp_right_found;
   count_type rsp_left_total;
   count_type rsp_right_total;
   logic      csr_wr_en = 1'b0;
   thr_type   csr_wr_data = '0;

   row_edge_tracker_diff_sum_ratio dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_out     (rsp_row_out),
      .rsp_left_edge   (rsp_left_edge),
      .rsp_right_edge  (rsp_right_edge),
      .rsp_center_col  (rsp_center_col),
      .rsp_left_found  (rsp_left_found),
      .rsp_right_found (rsp_right_found),
      .rsp_left_total  (rsp_left_total),
      .rsp_right_total (rsp_right_total),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Tracker state mirrored in the testbench
   thr_type   trk_thr = ThrReset;
   col_type   trk_center [ImageHeight] = '{default: '0};
   col_type   trk_start = HalfWidth;
   col_type   trk_left_start = '0;
   col_type   trk_right_start = LastCol;
   pix_type   trk_taps [3] = '{default: '0};
   col_type   trk_left_col = '0;
   col_type   trk_right_col = LastCol;
   logic      trk_left_hit = 1'b0;
   logic      trk_right_hit = 1'b0;
   count_type trk_left_cnt = '0;
   count_type trk_right_cnt = '0;

   edge_report_type row_results_due [$];
   pix_beat_type    pixel_queue [$];
   int beats_queued = 0;
   int beats_taken = 0;
   int mismatches = 0;

   // Stimulus shaping
   int lane_mid = 94;
   int lane_half = 40;
   int flat_level = 0;
   int hold_seq = 0;
   // columns sent besides the first and last; the rest of the row is skipped
   int span_lo = 0;
   int span_hi = ImageWidth - 1;

   // Advance the tracker by one pixel; queue the row report on the last column
   task automatic track_row_edges(input row_type r, input col_type c, input pix_type p);
      int a, b, diff, ctr, reach, lc, col, mid;
      logic hit;
      edge_report_type rep;
      a   = int'(trk_taps[2]);
      b   = int'(p);
      col = int'(c);
      trk_taps[2] = trk_taps[1];
      trk_taps[1] = trk_taps[0];
      trk_taps[0] = p;
      if (r == 0 || r >= ImageHeight || col >= ImageWidth) return;

      // row start: clear edges, move the search windows
      if (col == 0) begin
         trk_left_col  = '0;
         trk_right_col = LastCol;
         trk_left_hit  = 1'b0;
         trk_right_hit = 1'b0;
         if (r == FirstRow) begin
            trk_left_cnt    = '0;
            trk_right_cnt   = '0;
            trk_start       = HalfWidth;
            trk_left_start  = '0;
            trk_right_start = LastCol;
         end else begin
            ctr             = int'(trk_center[r]);
            trk_start       = col_type'((4 * ctr + 3 * int'(trk_start) + ImageWidth) / 10);
            trk_left_start  = trk_start;
            reach           = int'(trk_start) + (6 * ctr) / 10;
            trk_right_start = (reach > ImageWidth - 1) ? LastCol : col_type'(reach);
         end
      end

      // pair three columns apart; zero sum never counts
      if (col >= 3) begin
         diff = (a > b) ? a - b : b - a;
         hit  = (256 * diff) > (int'(trk_thr) * (a + b));
         lc   = col - 3;
         if (hit && !trk_left_hit && lc >= int'(trk_left_start) &&
             ((lc - int'(trk_left_start)) % 2) == 0) begin
            trk_left_hit = 1'b1;
            trk_left_col = col_type'(lc + 2);
         end
         if (hit && col <= int'(trk_right_start) &&
             ((int'(trk_right_start) - col) % 2) == 0) begin
            trk_right_hit = 1'b1;
            trk_right_col = col_type'(col - 2);
         end
      end

      if (col == ImageWidth - 1) begin
         mid = (int'(trk_left_col) + int'(trk_right_col)) / 2;
         if (trk_left_hit) trk_left_cnt = trk_left_cnt + 7'd1;
         if (trk_right_hit) trk_right_cnt = trk_right_cnt + 7'd1;
         trk_center[r] = col_type'(mid);
         rep.row       = r;
         rep.left_col  = trk_left_col;
         rep.right_col = trk_right_col;
         rep.center    = col_type'(mid);
         rep.left_hit  = trk_left_hit;
         rep.right_hit = trk_right_hit;
         rep.left_cnt  = trk_left_cnt;
         rep.right_cnt = trk_right_cnt;
         row_results_due.push_back(rep);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= PrintLimit)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Driver: bursts of beats with random gaps
   int           burst_left = 1;
   int           gap_left = 0;
   pix_beat_type drive_beat;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_row_edges(req_row_index, req_col_index, req_pixel);
            beats_taken++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
               drive_beat = pixel_queue.pop_front();
               req_valid     <= 1'b1;
               req_row_index <= drive_beat.row;
               req_col_index <= drive_beat.col;
               req_pixel     <= drive_beat.pix;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  case ($urandom_range(0, 3))
                     0: begin
                        burst_left = $urandom_range(1, 4);
                        gap_left   = $urandom_range(1, 10);
                     end
                     1: begin
                        burst_left = $urandom_range(8, 64);
                        gap_left   = $urandom_range(0, 3);
                     end
                     2: begin
                        burst_left = $urandom_range(200, 600);
                        gap_left   = 0;
                     end
                     default: begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = $urandom_range(1, 30);
                     end
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: changing ready pattern, plus a long hold on request
   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left = 0;
   int             hold_seen = 0;
   int             hold_left = 0;

   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = LongHold;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 2));
            mode_left  = $urandom_range(16, 300);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            default:      rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Monitor: each result beat against the oldest expected report
   always @(posedge clock) begin
      edge_report_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (row_results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= PrintLimit)
               $display("%0t: row report expected none, got row %0d", $time, rsp_row_out);
         end else begin
            due = row_results_due.pop_front();
            check_field("row_out", 16'(due.row), 16'(rsp_row_out));
            check_field("left_edge", 16'(due.left_col), 16'(rsp_left_edge));
            check_field("right_edge", 16'(due.right_col), 16'(rsp_right_edge));
            check_field("center_col", 16'(due.center), 16'(rsp_center_col));
            check_field("left_found", 16'(due.left_hit), 16'(rsp_left_found));
            check_field("right_found", 16'(due.right_hit), 16'(rsp_right_found));
            check_field("left_total", 16'(due.left_cnt), 16'(rsp_left_total));
            check_field("right_total", 16'(due.right_cnt), 16'(rsp_right_total));
         end
      end
   end

   // Watchdog: nothing moving on either side for too long
   int stuck_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles == StallLimit) begin
         $display("%0t: no beat accepted for %0d cycles", $time, StallLimit);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic queue_beat(input int r, input int c, input int p);
      pix_beat_type b;
      b.row = row_type'(r);
      b.col = col_type'(c);
      b.pix = pix_type'(p);
      pixel_queue.push_back(b);
      beats_queued++;
   endtask

   // A beat the tracker only shifts into its taps
   task automatic queue_junk();
      case ($urandom_range(0, 2))
         0: queue_beat(0, $urandom_range(0, ColMax), $urandom_range(0, 255));
         1: queue_beat($urandom_range(ImageHeight, RowMax), $urandom_range(0, ColMax),
                       $urandom_range(0, 255));
         default: queue_beat($urandom_range(1, ImageHeight - 1),
                             $urandom_range(ImageWidth, ColMax), $urandom_range(0, 255));
      endcase
   endtask

   function automatic int row_pixel(input row_style_type style, input int c);
      logic in_lane;
      in_lane = (c >= lane_mid - lane_half) && (c <= lane_mid + lane_half);
      case (style)
         ROW_LANE:    return in_lane ? $urandom_range(140, 200) + $urandom_range(0, 55)
                                     : $urandom_range(0, 70);
         // contrast close to the default ratio
         ROW_SOFT:    return in_lane ? $urandom_range(90, 110) : $urandom_range(60, 80);
         ROW_EXTREME: return in_lane ? 255 : 0;
         ROW_FLAT:    return flat_level;
         default:     return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic queue_row(input int r, input row_style_type style,
                            input row_noise_type noise);
      int cut;
      cut = $urandom_range(1, ImageWidth - 2);
      for (int c = 0; c < ImageWidth; c++) begin
         if (noise == NOISE_SHORT && c == cut) break;
         if (!((noise == NOISE_NO_COL0 && c == 0) || (noise == NOISE_SKIP && c == cut) ||
               (c != 0 && c != ImageWidth - 1 && (c < span_lo || c > span_hi))))
            queue_beat(r, c, row_pixel(style, c));
         if (noise == NOISE_REPEAT && c == cut) queue_beat(r, c, row_pixel(style, c));
         if (noise == NOISE_JUNK && c == cut) queue_junk();
      end
   endtask

   // Rows walking up the image with a drifting lane; wraps past row zero
   task automatic queue_frame(input int n_rows, input logic restart);
      int r, k, roll;
      row_style_type style;
      row_noise_type noise;
      r = restart ? int'(FirstRow) : $urandom_range(1, ImageHeight - 2);
      for (k = 0; k < n_rows; k++) begin
         lane_mid = lane_mid + $urandom_range(0, 8) - 4;
         if (lane_mid < 20) lane_mid = 20;
         if (lane_mid > ImageWidth - 21) lane_mid = ImageWidth - 21;
         lane_half = $urandom_range(15, 70);
         roll = $urandom_range(0, 19);
         if (roll < 12) style = ROW_LANE;
         else if (roll < 15) style = ROW_SOFT;
         else if (roll < 17) style = ROW_RANDOM;
         else if (roll < 18) style = ROW_EXTREME;
         else style = ROW_FLAT;
         if (style == ROW_FLAT)
            flat_level = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 255) : 0;
         // short stretch of columns around one lane border
         span_lo = (($urandom_range(0, 1) == 1) ? lane_mid - lane_half : lane_mid + lane_half)
                 - int'($urandom_range(2, 10));
         if (span_lo < 1) span_lo = 1;
         span_hi = span_lo + int'($urandom_range(5, 15));
         noise = ($urandom_range(0, 9) < 8) ? NOISE_NONE
                                            : row_noise_type'($urandom_range(1, 5));
         queue_row(r, style, noise);
         roll = $urandom_range(0, 15);
         r = r - ((roll == 0) ? 0 : (roll == 1) ? 2 : 1);
         if (r < 1) begin
            queue_row(0, ROW_RANDOM, NOISE_NONE);
            r = ImageHeight - 2;
         end
      end
   endtask

   // Wait for all beats taken and all reports back, then let the pipe settle
   task automatic drain();
      while (beats_taken != beats_queued || row_results_due.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_threshold(input int value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= thr_type'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      trk_thr = thr_type'(value);
   endtask

   initial begin
      int roll;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ignored beats first, so the taps are filled before any comparison
      queue_beat(0, 0, 0);
      queue_beat(0, 1, 255);
      queue_beat(RowMax, 3, 170);
      queue_beat(int'(FirstRow), ColMax, 85);
      queue_beat(5, ImageWidth, 0);

      // default threshold: bright lane to the row end, dark zero-sum border
      lane_mid  = 100;
      lane_half = 90;
      queue_row(int'(FirstRow), ROW_EXTREME, NOISE_NONE);
      span_lo    = 2;
      span_hi    = 30;
      flat_level = 0;
      queue_row(int'(FirstRow) - 1, ROW_FLAT, NOISE_NONE);
      span_lo    = 150;
      span_hi    = 175;
      flat_level = 255;
      queue_row(int'(FirstRow) - 2, ROW_FLAT, NOISE_NONE);
      span_lo   = 0;
      span_hi   = ImageWidth - 1;
      lane_mid  = 60;
      lane_half = 25;
      queue_row(int'(FirstRow) - 3, ROW_LANE, NOISE_NONE);
      drain();

      // zero threshold: any difference is an edge
      set_threshold(0);
      span_lo = 20;
      span_hi = 40;
      queue_row(int'(FirstRow) - 4, ROW_RANDOM, NOISE_NONE);
      span_lo    = 100;
      span_hi    = 115;
      flat_level = 37;
      queue_row(int'(FirstRow) - 5, ROW_FLAT, NOISE_NONE);
      drain();

      // full-scale threshold: nothing can pass
      set_threshold(ThrMax);
      span_lo = 30;
      span_hi = 45;
      queue_row(int'(FirstRow) - 6, ROW_EXTREME, NOISE_NONE);
      span_lo = 60;
      span_hi = 80;
      queue_row(int'(FirstRow) - 7, ROW_RANDOM, NOISE_NONE);
      drain();

      // random phases, each at its own threshold
      for (int ph = 0; ph < 8; ph++) begin
         roll = $urandom_range(0, 9);
         if (ph == 5) set_threshold(int'(ThrReset));
         else if (roll == 0) set_threshold(0);
         else if (roll == 1) set_threshold(ThrMax);
         else set_threshold($urandom_range(20, 120));
         if (ph == 3) begin
            hold_seq++;
            queue_frame(4, 1'b1);
         end else begin
            queue_frame($urandom_range(2, 3), $urandom_range(0, 3) != 0);
         end
         drain();
      end

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
